### rtl/blc_pkg.sv
package blc_pkg;

  // Fixed widths of the transaction fields and of the configuration port.
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned THR_W      = 33;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 33;

  // Defaults for the top-level parameters.
  localparam int unsigned NODE_COUNT_DEF  = 64;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Register reset values.
  localparam logic [THR_W-1:0]  G2B_RESET   = 33'd1073741824;
  localparam logic [THR_W-1:0]  B2G_RESET   = 33'd4294967296;
  localparam logic [THR_W-1:0]  INIT_RESET  = 33'd858993459;
  localparam logic [WORD_W-1:0] SEED_RESET  = 32'd1;
  localparam logic [WORD_W-1:0] WARM_RESET  = 32'd0;
  localparam logic [WORD_W-1:0] SEED_ZERO_SUB = 32'd1;

  // Shift amounts of the xorshift32 generator.
  localparam int unsigned XS_A = 13;
  localparam int unsigned XS_B = 17;
  localparam int unsigned XS_C = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_G2B_THR  = 3'd0,
    REG_B2G_THR  = 3'd1,
    REG_INIT_THR = 3'd2,
    REG_SEED     = 3'd3,
    REG_WARMUP   = 3'd4
  } blc_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0] sender_index;
    logic [IDX_W-1:0] receiver_index;
  } blc_in_t;

  typedef struct packed {
    logic deliver;
    logic bypassed;
  } blc_out_t;

  // Transition thresholds seen by the back end.
  typedef struct packed {
    logic [THR_W-1:0] good_to_bad;
    logic [THR_W-1:0] bad_to_good;
    logic [THR_W-1:0] initial_bad;
  } blc_thr_t;

  // Generator reseed request from the register file.
  typedef struct packed {
    logic              load;
    logic [WORD_W-1:0] seed;
  } blc_seed_t;

  function automatic logic [WORD_W-1:0] xorshift32(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x ^ (x << XS_A);
    y = y ^ (y >> XS_B);
    y = y ^ (y << XS_C);
    return y;
  endfunction

  // A draw hits when the raw word is strictly below the threshold.
  function automatic logic draw_hits(input logic [WORD_W-1:0] w,
                                     input logic [THR_W-1:0]  thr);
    return {1'b0, w} < thr;
  endfunction

endpackage

### rtl/burst_loss_link_channel.sv
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-----------------------------------
// in        | input     | in_valid_i / in_stall_o  | blc_in_t: sender, receiver index
// out       | output    | out_valid_o / out_stall_i| blc_out_t: deliver, bypassed
// cfg       | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i (33 bit)
//
// One frame is taken per cycle while in_stall_o is low; its result passes the job queue,
// the registered link-state memory read and the result register, in that order.
// After reset a clearing pass runs over all NODE_COUNT * NODE_COUNT seen flags
// (4096 by default); no frame is taken during it, register writes are.
// A stall on the output holds the result register and fills the job queue
// before the input is stalled; the input never waits for an idle state.
module burst_loss_link_channel import blc_pkg::*; #(
  parameter int unsigned NODE_COUNT  = NODE_COUNT_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  blc_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output blc_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Each link of the NODE_COUNT x NODE_COUNT matrix has one memory entry.
  localparam int unsigned LINK_W = $clog2(NODE_COUNT * NODE_COUNT);

  // Register file. Writes are always accepted; the block is idle by contract
  // whenever one arrives, so they take effect at once.
  logic [THR_W-1:0]  g2b_q, b2g_q, init_q;
  logic [WORD_W-1:0] warmup_q;
  logic              cfg_we;
  blc_thr_t          thr;
  blc_seed_t         seed_req;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g2b_q    <= G2B_RESET;
      b2g_q    <= B2G_RESET;
      init_q   <= INIT_RESET;
      warmup_q <= WARM_RESET;
    end else if (cfg_we) begin
      case (blc_reg_e'(cfg_index_i))
        REG_G2B_THR:  g2b_q    <= cfg_data_i;
        REG_B2G_THR:  b2g_q    <= cfg_data_i;
        REG_INIT_THR: init_q   <= cfg_data_i;
        REG_WARMUP:   warmup_q <= cfg_data_i[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // A seed write reloads the generator directly; the seed itself is not kept.
  assign seed_req.load = cfg_we && (blc_reg_e'(cfg_index_i) == REG_SEED);
  assign seed_req.seed = cfg_data_i[WORD_W-1:0];

  assign thr.good_to_bad = g2b_q;
  assign thr.bad_to_good = b2g_q;
  assign thr.initial_bad = init_q;

  // Front end: range check, warmup counting and link address; each frame
  // becomes one queue entry holding a bypass flag and the link address.
  logic            q_push, q_full, q_valid, q_pop, clr_busy;
  logic [LINK_W:0] q_push_data, q_pop_data;

  blc_front #(
    .NODE_COUNT (NODE_COUNT),
    .LINK_W     (LINK_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .warmup_i    (warmup_q),
    .clr_busy_i  (clr_busy),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  // Job queue: lets the front keep taking frames while the result waits.
  blc_fifo #(
    .DATA_W (LINK_W + 1),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_pop_data)
  );

  // Back end: link-state memory, shared generator and result register.
  // Bypassed frames pass through without writing memory or stepping the generator.
  blc_back #(
    .NODE_COUNT (NODE_COUNT),
    .LINK_W     (LINK_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_data_i  (q_pop_data),
    .job_pop_o   (q_pop),
    .thr_i       (thr),
    .seed_i      (seed_req),
    .clr_busy_o  (clr_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/blc_fifo.sv
module blc_fifo import blc_pkg::*; #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue occupancy beyond its depth");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("queue occupancy did not follow a lone push");
`endif

endmodule

### rtl/blc_front.sv
module blc_front import blc_pkg::*; #(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF,
  parameter int unsigned LINK_W     = $clog2(NODE_COUNT * NODE_COUNT)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  blc_in_t           in_data_i,
  input  logic [WORD_W-1:0] warmup_i,
  input  logic              clr_busy_i,
  input  logic              q_full_i,
  output logic              push_o,
  output logic [LINK_W:0]   push_data_o
);

  localparam logic [IDX_W:0] NODE_LIM = (IDX_W + 1)'(NODE_COUNT);

  logic [WORD_W-1:0] frame_q, frame_d;
  logic              accept, in_range, in_warmup;
  logic [LINK_W-1:0] link;

  assign in_stall_o = q_full_i || clr_busy_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = ({1'b0, in_data_i.sender_index} < NODE_LIM) &&
                      ({1'b0, in_data_i.receiver_index} < NODE_LIM);
  assign in_warmup  = frame_q < warmup_i;
  assign link       = LINK_W'(in_data_i.sender_index) * LINK_W'(NODE_COUNT) +
                      LINK_W'(in_data_i.receiver_index);

  assign push_o      = accept;
  assign push_data_o = {!in_range || in_warmup, link};

  always_comb begin
    frame_d = frame_q;
    if (accept && in_range && in_warmup) begin
      frame_d = frame_q + WORD_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else begin
      frame_q <= frame_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_i |-> !push_o)
    else $error("frame taken during the clearing pass");

  a_count_warm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_range && in_warmup) |=> (frame_q == $past(frame_q) + WORD_W'(1)))
    else $error("warmup counter missed an in-range frame");
`endif

endmodule

### rtl/blc_back.sv
module blc_back import blc_pkg::*; #(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF,
  parameter int unsigned LINK_W     = $clog2(NODE_COUNT * NODE_COUNT)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  logic [LINK_W:0] job_data_i,
  output logic            job_pop_o,
  input  blc_thr_t        thr_i,
  input  blc_seed_t       seed_i,
  output logic            clr_busy_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output blc_out_t        out_data_o
);

  localparam int unsigned LINK_TOTAL = NODE_COUNT * NODE_COUNT;

  logic seen_mem [LINK_TOTAL];
  logic bad_mem  [LINK_TOTAL];

  logic              seen_rd_q, bad_rd_q;
  logic              s1_valid_q, s1_bypass_q;
  logic [LINK_W-1:0] s1_link_q;
  logic              lw_valid_q, lw_bad_q;
  logic [LINK_W-1:0] lw_link_q;
  logic [WORD_W-1:0] rng_q;
  logic              clr_busy_q;
  logic [LINK_W-1:0] clr_addr_q;
  logic              out_valid_q;
  blc_out_t          out_data_q;

  logic              advance, issue, chain_adv, fwd;
  logic              seen, bad, cur, next_bad;
  logic [WORD_W-1:0] draw_a, draw_b, draw_t;
  logic              seen_we, seen_wd;
  logic [LINK_W-1:0] wr_addr;

  assign advance   = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign issue     = job_valid_i && !clr_busy_q && (!s1_valid_q || advance);
  assign chain_adv = advance && !s1_bypass_q;
  assign job_pop_o = issue;

  // The entry written on the previous chain step may not be in the read data yet.
  assign fwd    = lw_valid_q && (lw_link_q == s1_link_q);
  assign seen   = fwd ? 1'b1 : seen_rd_q;
  assign bad    = fwd ? lw_bad_q : bad_rd_q;
  assign draw_a = xorshift32(rng_q);
  assign draw_b = xorshift32(draw_a);
  assign cur    = seen ? bad : draw_hits(draw_a, thr_i.initial_bad);
  assign draw_t = seen ? draw_a : draw_b;
  assign next_bad = cur ? !draw_hits(draw_t, thr_i.bad_to_good)
                        : draw_hits(draw_t, thr_i.good_to_bad);

  assign seen_we = clr_busy_q || chain_adv;
  assign seen_wd = !clr_busy_q;
  assign wr_addr = clr_busy_q ? clr_addr_q : s1_link_q;

  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_mem[wr_addr] <= seen_wd;
    end
    if (issue) begin
      seen_rd_q <= seen_mem[job_data_i[LINK_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_adv) begin
      bad_mem[s1_link_q] <= next_bad;
    end
    if (issue) begin
      bad_rd_q <= bad_mem[job_data_i[LINK_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + LINK_W'(1);
      if (clr_addr_q == LINK_W'(LINK_TOTAL - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      lw_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rng_q       <= SEED_RESET;
    end else begin
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (chain_adv) begin
        lw_valid_q <= 1'b1;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (seed_i.load) begin
        rng_q <= (seed_i.seed == '0) ? SEED_ZERO_SUB : seed_i.seed;
      end else if (chain_adv) begin
        rng_q <= draw_t;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_bypass_q <= job_data_i[LINK_W];
      s1_link_q   <= job_data_i[LINK_W-1:0];
    end
    if (chain_adv) begin
      lw_link_q <= s1_link_q;
      lw_bad_q  <= next_bad;
    end
    if (advance) begin
      out_data_q.deliver  <= s1_bypass_q ? 1'b1 : !cur;
      out_data_q.bypassed <= s1_bypass_q;
    end
  end

  assign clr_busy_o  = clr_busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_link_q)))
    else $error("held chain stage lost its frame");

  a_no_step_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !chain_adv)
    else $error("chain step during the clearing pass");

  a_rng_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rng_q != '0)
    else $error("generator fell into the all-zero state");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import blc_pkg::*;

  localparam int unsigned NODES       = NODE_COUNT_DEF;
  localparam int unsigned LINKS       = NODES * NODES;
  localparam logic [THR_W-1:0] THR_ALL = 33'h1_0000_0000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  blc_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  blc_out_t              out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  burst_loss_link_channel #(
    .NODE_COUNT(NODES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the channel: registers, generator, warmup count and link chains.
  logic [THR_W-1:0]  thr_good_bad  = G2B_RESET;
  logic [THR_W-1:0]  thr_bad_good  = B2G_RESET;
  logic [THR_W-1:0]  thr_first_bad = INIT_RESET;
  logic [WORD_W-1:0] warm_limit    = WARM_RESET;
  logic [WORD_W-1:0] xs_state      = SEED_RESET;
  logic [WORD_W-1:0] frame_count   = '0;
  bit                link_is_bad [LINKS];
  bit                link_used   [LINKS];

  blc_in_t     pending_frames[$];
  blc_out_t    expected_verdicts[$];
  int unsigned frames_issued = 0;
  int unsigned frames_taken  = 0;
  int unsigned mismatches    = 0;
  int unsigned tx_gap        = 0;
  int unsigned tx_quiet      = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_quiet      = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Advances the shared generator by one step and tests the new word against a limit.
  function automatic logic draw_below(input logic [THR_W-1:0] limit);
    logic [WORD_W-1:0] w;
    w = xs_state;
    w = w ^ {w[18:0], 13'b0};
    w = w ^ {17'b0, w[31:17]};
    w = w ^ {w[26:0], 5'b0};
    xs_state = w;
    return {1'b0, w} < limit;
  endfunction

  // Works out the verdict for one frame and steps the shadow state.
  function automatic blc_out_t channel_verdict(input blc_in_t f);
    blc_out_t    v;
    int unsigned link;
    logic        now_bad;
    v.deliver  = 1'b1;
    v.bypassed = 1'b1;
    if (f.sender_index >= NODES || f.receiver_index >= NODES) return v;
    if (frame_count < warm_limit) begin
      frame_count = frame_count + 1;
      return v;
    end
    link = f.sender_index * NODES + f.receiver_index;
    if (!link_used[link]) begin
      link_is_bad[link] = draw_below(thr_first_bad);
      link_used[link]   = 1'b1;
    end
    now_bad = link_is_bad[link];
    if (now_bad) begin
      link_is_bad[link] = !draw_below(thr_bad_good);
    end else begin
      link_is_bad[link] = draw_below(thr_good_bad);
    end
    v.deliver  = !now_bad;
    v.bypassed = 1'b0;
    return v;
  endfunction

  // Mostly back-to-back, often short gaps, now and then a long one,
  // and occasional quiet stretches with no idling at all.
  function automatic int unsigned idle_cycles(inout int unsigned quiet);
    int unsigned r;
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return THR_ALL;
      2: return THR_W'($urandom_range(1, 16));
      3: return THR_ALL - 1;
      default: return {1'b0, $urandom()};
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_frame(input int unsigned snd, input int unsigned rcv);
    blc_in_t f;
    f.sender_index   = IDX_W'(snd);
    f.receiver_index = IDX_W'(rcv);
    pending_frames.push_back(f);
    frames_issued++;
  endtask

  // Mostly in-range frames, many on a handful of links so that chains get revisited.
  task automatic queue_random_frame();
    int unsigned r;
    int unsigned a;
    int unsigned b;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      a = $urandom_range(0, 255);
      b = $urandom_range(NODES, 255);
      if ($urandom_range(0, 1)) queue_frame(a, b);
      else queue_frame(b, a);
    end else if (r < 18) begin
      queue_frame($urandom_range(0, 255), $urandom_range(0, 255));
    end else if (r < 65) begin
      queue_frame($urandom_range(0, 3), $urandom_range(0, 3));
    end else begin
      queue_frame($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));
    end
  endtask

  // Called just after a rising edge. The valid stays high so that writes can follow
  // one another; the caller lowers it after the last one.
  task automatic write_reg(input blc_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_G2B_THR:  thr_good_bad  = val;
      REG_B2G_THR:  thr_bad_good  = val;
      REG_INIT_THR: thr_first_bad = val;
      REG_SEED:     xs_state      = (val[WORD_W-1:0] == '0) ? SEED_ZERO_SUB : val[WORD_W-1:0];
      REG_WARMUP:   warm_limit    = val[WORD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (frames_taken != frames_issued || expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Frame driver: the payload only moves once the current transaction has gone.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_verdicts.push_back(channel_verdict(in_data_i));
        frames_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap != 0) begin
          in_valid_i <= 1'b0;
          tx_gap--;
        end else if (pending_frames.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_frames.pop_front();
          tx_gap = idle_cycles(tx_quiet);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Verdict monitor and random back-pressure on the result side.
  always @(posedge clk_i) begin : result_monitor
    blc_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict arrived with no frame outstanding");
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data_o.deliver !== want.deliver)
            report_mismatch($sformatf("deliver is %b, expected %b",
                                      out_data_o.deliver, want.deliver));
          if (out_data_o.bypassed !== want.bypassed)
            report_mismatch($sformatf("bypassed is %b, expected %b",
                                      out_data_o.bypassed, want.bypassed));
        end
      end
      if (rx_stall_left != 0) begin
        out_stall_i <= 1'b1;
        rx_stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        rx_stall_left = idle_cycles(rx_quiet);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: index extremes, out-of-range on either side and repeated links.
    queue_frame(0, 0);
    queue_frame(0, 0);
    queue_frame(0, 1);
    queue_frame(NODES - 1, NODES - 1);
    queue_frame(NODES - 1, 0);
    queue_frame(NODES, 0);
    queue_frame(0, NODES);
    queue_frame(255, 255);
    queue_frame(128, 5);
    queue_frame(5, 127);
    queue_frame(0, 0);
    queue_frame(NODES - 1, NODES - 1);
    wait_drained();

    // Warmup with a zero seed; out-of-range frames must not count towards it.
    // Once past warmup the link starts good, goes bad and never recovers.
    write_reg(REG_SEED, '0);
    write_reg(REG_WARMUP, 33'd4);
    write_reg(REG_G2B_THR, THR_ALL);
    write_reg(REG_B2G_THR, '0);
    write_reg(REG_INIT_THR, '0);
    cfg_valid_i <= 1'b0;
    queue_frame(200, 1);
    repeat (7) queue_frame(2, 3);
    wait_drained();

    // Warmup limit dropped below the frame count: chains engage at once.
    // Fresh links start bad and always recover.
    write_reg(REG_WARMUP, 33'd2);
    write_reg(REG_INIT_THR, THR_ALL);
    write_reg(REG_B2G_THR, THR_ALL);
    write_reg(REG_G2B_THR, '0);
    write_reg(REG_SEED, 33'h0_FFFF_FFFF);
    cfg_valid_i <= 1'b0;
    queue_frame(7, 9);
    queue_frame(7, 9);
    queue_frame(7, 9);
    queue_frame(9, 7);
    wait_drained();

    // Largest warmup limit: every in-range frame is waved through.
    write_reg(REG_WARMUP, 33'h0_FFFF_FFFF);
    write_reg(REG_G2B_THR, THR_ALL - 1);
    write_reg(REG_B2G_THR, 33'd1);
    write_reg(REG_INIT_THR, 33'd1);
    cfg_valid_i <= 1'b0;
    queue_frame(1, 1);
    queue_frame(NODES - 1, 2);
    queue_frame(3, 0);

    // Random phases, each under its own settings; the first rewrites everything.
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      if (phase == 0 || $urandom_range(0, 1)) write_reg(REG_G2B_THR, pick_threshold());
      if (phase == 0 || $urandom_range(0, 1)) write_reg(REG_B2G_THR, pick_threshold());
      if (phase == 0 || $urandom_range(0, 1)) write_reg(REG_INIT_THR, pick_threshold());
      if (phase == 0 || $urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 4) == 0) write_reg(REG_SEED, '0);
        else write_reg(REG_SEED, {1'b0, $urandom()});
      end
      if (phase == 0 || $urandom_range(0, 1)) begin
        if ($urandom_range(0, 2) == 0) write_reg(REG_WARMUP, CFG_DATA_W'($urandom_range(0, 30)));
        else write_reg(REG_WARMUP, '0);
      end
      cfg_valid_i <= 1'b0;
      repeat (80) queue_random_frame();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Allows for the clearing pass after reset and the slowest mix of gaps and stalls.
  initial begin
    #5_000_000;
    $display("Timeout with %0d frames still awaiting a verdict",
             frames_issued - frames_taken + expected_verdicts.size());
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
rtl/blc_pkg.sv
rtl/blc_fifo.sv
rtl/blc_front.sv
rtl/blc_back.sv
rtl/burst_loss_link_channel.sv
bench/testbench.sv
